/* hdl/sms_pkg.sv */
// Shared types and constants for the sorted matrix search block.
package sms_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLS_IN_USE = 2'd1;

    // Request kinds carried on s_tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Input beat layout in s_tdata
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + IDX_W;
    localparam int WVAL_LSB   = COL_LSB + IDX_W;
    localparam int SVAL_LSB   = WVAL_LSB + DATA_W;
    localparam int S_FIELDS_W = SVAL_LSB + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Active matrix dimensions as handed to the search core
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } cfg_t;

    // Search outcome offered by the core
    typedef struct packed {
        logic valid;
        logic found;
    } res_t;

endpackage

/* hdl/sms_core.sv */
// Element store and two-phase binary search sequencer.
module sms_core
    import sms_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_type,
    input  logic [IDX_W-1:0]         in_row,
    input  logic [IDX_W-1:0]         in_col,
    input  logic signed [DATA_W-1:0] in_wval,
    input  logic signed [DATA_W-1:0] in_sval,
    output res_t                     res,
    input  logic                     res_ready
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_FIRST,
        S_ROW_LAST,
        S_ROW_CHECK,
        S_COL_PROBE,
        S_COL_CHECK,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [CFG_W-1:0]         lo_reg;
    logic [CFG_W-1:0]         hi_reg;      // exclusive upper bound
    logic [CFG_W-1:0]         mid_reg;
    logic [CFG_W-1:0]         nc_reg;
    logic [AW-1:0]            base_reg;    // address of column 0 of the probed row
    logic signed [DATA_W-1:0] first_reg;
    logic signed [DATA_W-1:0] target_reg;
    logic                     found_reg;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    logic [CFG_W-1:0] nr;
    logic [CFG_W-1:0] nc;
    logic [CFG_W:0]   mid_sum;
    logic [CFG_W-1:0] mid;
    logic             range_empty;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    // Clamp counts to the store size
    always_comb begin
        nr = (int'(cfg.rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : cfg.rows;
        nc = (int'(cfg.cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg.cols;
    end

    // Probe index, floor of (lo + hi - 1) / 2
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg} - (CFG_W+1)'(1);
    assign mid         = mid_sum[CFG_W:1];
    assign range_empty = (lo_reg >= hi_reg);

    assign in_ready = (state_reg == S_IDLE);

    // Write port: element writes land directly from the input beat
    assign wr_en   = in_valid && in_ready && (in_type == REQ_WRITE) &&
                     (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
    assign wr_addr = AW'(int'(in_row) * MAX_COLS + int'(in_col));

    // Read port address select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = base_reg;
        unique case (state_reg)
            S_ROW_FIRST: begin
                rd_en   = !range_empty;
                rd_addr = AW'(int'(mid) * MAX_COLS);
            end
            S_ROW_LAST: begin
                rd_en   = 1'b1;
                rd_addr = AW'(int'(base_reg) + int'(nc_reg) - 1);
            end
            S_COL_PROBE: begin
                rd_en   = !range_empty;
                rd_addr = AW'(int'(base_reg) + int'(mid));
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = base_reg;
            end
        endcase
    end

    // Element store, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_wval;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && (in_type == REQ_SEARCH)) begin
                        target_reg <= in_sval;
                        nc_reg     <= nc;
                        lo_reg     <= '0;
                        hi_reg     <= nr;
                        found_reg  <= 1'b0;
                        state_reg  <= (nr == '0 || nc == '0) ? S_DONE : S_ROW_FIRST;
                    end
                end
                S_ROW_FIRST: begin
                    if (range_empty) begin
                        state_reg <= S_DONE;
                    end else begin
                        mid_reg   <= mid;
                        base_reg  <= AW'(int'(mid) * MAX_COLS);
                        state_reg <= S_ROW_LAST;
                    end
                end
                S_ROW_LAST: begin
                    // first element of the row is on the read port now
                    first_reg <= rd_data_reg;
                    state_reg <= S_ROW_CHECK;
                end
                S_ROW_CHECK: begin
                    // last element of the row is on the read port now
                    priority if (first_reg <= target_reg && rd_data_reg >= target_reg) begin
                        lo_reg    <= '0;
                        hi_reg    <= nc_reg;
                        state_reg <= S_COL_PROBE;
                    end else if (first_reg > target_reg) begin
                        hi_reg    <= mid_reg;
                        state_reg <= S_ROW_FIRST;
                    end else begin
                        lo_reg    <= mid_reg + CFG_W'(1);
                        state_reg <= S_ROW_FIRST;
                    end
                end
                S_COL_PROBE: begin
                    if (range_empty) begin
                        state_reg <= S_DONE;
                    end else begin
                        mid_reg   <= mid;
                        state_reg <= S_COL_CHECK;
                    end
                end
                S_COL_CHECK: begin
                    priority if (rd_data_reg == target_reg) begin
                        found_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (rd_data_reg > target_reg) begin
                        hi_reg    <= mid_reg;
                        state_reg <= S_COL_PROBE;
                    end else begin
                        lo_reg    <= mid_reg + CFG_W'(1);
                        state_reg <= S_COL_PROBE;
                    end
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid = (state_reg == S_DONE);
    assign res.found = found_reg;

endmodule

/* hdl/sorted_matrix_search.sv */
// Top level of the sorted matrix search block: config registers, ports, result register.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tuser = req_type; s_tdata = row, col, values
//  m_        out        m_tvalid/m_tready   m_tdata = found
//  cfg_      in         cfg_we              cfg_addr = register index, cfg_wdata = value
//
//  A write beat lands its element in the store at the accepting edge.
//  A search runs row probes, each reading the first and last element of a row, and then
//  column probes, each reading one element, through the single read port of the store.
//  Reset (aresetn low, synchronous) sets rows_in_use = 0 and cols_in_use = 1; the store
//  keeps its contents and is not cleared.
//  A result waiting on m_ holds the sequencer in its final step; once the result is in
//  the output register the next beat is accepted while m_tready is still low.
module sorted_matrix_search
    import sms_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row_index[5:0], col_index[11:6],
                                             // write_value[43:12], search_value[75:44]
    input  logic                  s_tuser,   // req_type
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // found[0]
);

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic             m_tvalid_reg;
    logic             found_out_reg;
    cfg_t             cfg;
    res_t             res;
    logic             res_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0;
            cols_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ROWS_IN_USE: rows_reg <= cfg_wdata;
                REG_COLS_IN_USE: cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.rows = rows_reg;
    assign cfg.cols = cols_reg;

    sms_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_row    (s_tdata[ROW_LSB +: IDX_W]),
        .in_col    (s_tdata[COL_LSB +: IDX_W]),
        .in_wval   ($signed(s_tdata[WVAL_LSB +: DATA_W])),
        .in_sval   ($signed(s_tdata[SVAL_LSB +: DATA_W])),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res.valid) begin
            found_out_reg <= res.found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-1)'(0), found_out_reg};

endmodule

/* hdl/sms_checker.sv */
// Port-level checks for the sorted matrix search block, bound to the top level.
module sms_checker
    import sms_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds its value
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Out of reset: no result pending, input side open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // A fresh result never appears right after an accepted input beat
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result raised one cycle after an input beat");

    // Only the found bit is ever set in the result beat
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("padding bits set in result beat");

endmodule

bind sorted_matrix_search sms_checker u_sms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
